>>> rtl/core/rrp_pkg.sv
// ----------------------------------------------------------------------------
// rrp_pkg
// Shared widths and stage payload types for the radial repulsion push unit.
// ----------------------------------------------------------------------------
package rrp_pkg;

    localparam int COORD_BITS   = 16;
    localparam int FRAC_BITS    = 4;
    localparam int RADIUS_BITS  = 12;
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 12'd1280;
    localparam int SQRT_EXTRA   = 8;
    // dx, dy are limited to 12 bits of magnitude when in range
    localparam int DMAG_BITS    = 12;
    // dist2 < 2^25, shifted by 16 -> 41 bits, root 21 bits
    localparam int D2_BITS      = 25;
    localparam int RAD_BITS     = D2_BITS + 2 * SQRT_EXTRA;
    localparam int ROOT_BITS    = 21;
    // overlap < 2^20, numerator < 2^32
    localparam int OVL_BITS     = RADIUS_BITS + SQRT_EXTRA;
    localparam int NUM_BITS     = DMAG_BITS + OVL_BITS;
    // den = 5 * dist < 2^24
    localparam int DEN_BITS     = ROOT_BITS + 3;
    // quotient of (2num+den)/(2den) fits in NUM_BITS
    localparam int QUO_BITS     = NUM_BITS + 1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] mouse_x;
        logic signed [COORD_BITS-1:0] mouse_y;
    } push_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] new_x;
        logic signed [COORD_BITS-1:0] new_y;
        logic                         moved;
    } push_result_t;

    typedef logic [RADIUS_BITS-1:0] radius_t;

endpackage

>>> rtl/core/rrp_if.sv
// ----------------------------------------------------------------------------
// rrp_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface rrp_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/radial_repulsion_push_unit.sv
// ----------------------------------------------------------------------------
// radial_repulsion_push_unit
// Pushes points out of a repeller circle: square root, divide, saturation.
// ----------------------------------------------------------------------------
// Steps: diff, range, square, compare, root, overlap, product, divide, output.
// Throughput: one transaction per cycle; the square root and divider are
// fully pipelined, one bit per stage, and the whole pipe halts on back-pressure.
// Reset: valid bits clear, radius_reg returns to 80 px (1280).
module radial_repulsion_push_unit (
    input  logic clk,
    input  logic rst_n,
    rrp_if.sink   in_ch,
    rrp_if.source out_ch,
    rrp_if.sink   cfg
);
    import rrp_pkg::*;

    localparam int CW  = COORD_BITS;
    localparam int DW  = COORD_BITS + 1;
    localparam int TB  = 2 * CW + 2 * DMAG_BITS + 2 + RADIUS_BITS;
    localparam logic [D2_BITS+7:0] THRESH = (D2_BITS+8)'(1) << (2 * FRAC_BITS);

    logic [RADIUS_BITS-1:0] radius_reg;
    logic en;
    assign en = out_ch.ready || !out_ch.valid;
    assign in_ch.ready = en;
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg.valid)
        begin
            radius_reg <= cfg.data[RADIUS_BITS-1:0];
        end
    end

    // stage 1: differences
    logic              v1_reg;
    logic signed [CW-1:0] px1_reg, py1_reg;
    logic signed [DW-1:0] dx1_reg, dy1_reg;
    logic [RADIUS_BITS-1:0] r1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else if (en) v1_reg <= in_ch.valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px1_reg <= CW'(in_ch.data.point_x);
            py1_reg <= CW'(in_ch.data.point_y);
            dx1_reg <= DW'(signed'(in_ch.data.point_x)) - DW'(signed'(in_ch.data.mouse_x));
            dy1_reg <= DW'(signed'(in_ch.data.point_y)) - DW'(signed'(in_ch.data.mouse_y));
            r1_reg  <= radius_reg;
        end
    end

    // stage 2: range check, magnitudes
    logic [DW-1:0] adx, ady;
    assign adx = dx1_reg[DW-1] ? DW'(-dx1_reg) : DW'(dx1_reg);
    assign ady = dy1_reg[DW-1] ? DW'(-dy1_reg) : DW'(dy1_reg);
    logic v2_reg, near2_reg, sx2_reg, sy2_reg;
    logic [DMAG_BITS-1:0] mx2_reg, my2_reg;
    logic signed [CW-1:0] px2_reg, py2_reg;
    logic [RADIUS_BITS-1:0] r2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v2_reg <= 1'b0;
        else if (en) v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            near2_reg <= (adx <= DW'(4095)) && (ady <= DW'(4095));
            mx2_reg <= adx[DMAG_BITS-1:0];
            my2_reg <= ady[DMAG_BITS-1:0];
            sx2_reg <= dx1_reg[DW-1];
            sy2_reg <= dy1_reg[DW-1];
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
            r2_reg  <= r1_reg;
        end
    end

    // stage 3: squares
    logic v3_reg;
    logic [2*DMAG_BITS-1:0] sqx3_reg, sqy3_reg, rr3_reg;
    logic [TB-1:0] t3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v3_reg <= 1'b0;
        else if (en) v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx3_reg <= mx2_reg * mx2_reg;
            sqy3_reg <= my2_reg * my2_reg;
            rr3_reg  <= r2_reg * r2_reg;
            t3_reg   <= {px2_reg, py2_reg, mx2_reg, my2_reg, sx2_reg, sy2_reg, r2_reg};
        end
    end
    logic near3_reg;
    always_ff @(posedge clk)
    begin
        if (en) near3_reg <= near2_reg;
    end

    // stage 4: sum, compare
    logic [D2_BITS-1:0] d2;
    assign d2 = D2_BITS'(sqx3_reg) + D2_BITS'(sqy3_reg);
    logic v4_reg, in4_reg;
    logic [D2_BITS-1:0] d24_reg;
    logic [TB-1:0] t4_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v4_reg <= 1'b0;
        else if (en) v4_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in4_reg <= near3_reg && (d2 < D2_BITS'(rr3_reg))
                && ((D2_BITS+8)'(d2) * (D2_BITS+8)'(100) > THRESH);
            d24_reg <= d2;
            t4_reg  <= t3_reg;
        end
    end

    // square root
    logic              sv;
    logic [ROOT_BITS-1:0] root;
    logic [TB:0]       st;
    rrp_sqrt #(.IN_BITS(RAD_BITS), .OUT_BITS(ROOT_BITS), .TAG_BITS(TB+1)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v4_reg), .in_rad({d24_reg, (2*SQRT_EXTRA)'(0)}),
        .in_tag({in4_reg, t4_reg}),
        .out_valid(sv), .out_root(root), .out_tag(st)
    );

    logic [RADIUS_BITS-1:0] r_s;
    assign r_s = st[RADIUS_BITS-1:0];

    // stage 5: overlap, denominator
    logic v5_reg;
    logic [OVL_BITS-1:0] ovl5_reg;
    logic [DEN_BITS-1:0] den5_reg;
    logic [TB:0] t5_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v5_reg <= 1'b0;
        else if (en) v5_reg <= sv;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovl5_reg <= {r_s, SQRT_EXTRA'(0)} - OVL_BITS'(root);
            den5_reg <= DEN_BITS'(root) * DEN_BITS'(5);
            t5_reg   <= st;
        end
    end

    // stage 6: products, rounded numerators
    logic [DMAG_BITS-1:0] mx5, my5;
    assign mx5 = t5_reg[2*DMAG_BITS+2+RADIUS_BITS-1 -: DMAG_BITS];
    assign my5 = t5_reg[DMAG_BITS+2+RADIUS_BITS-1 -: DMAG_BITS];
    logic v6_reg;
    logic [QUO_BITS-1:0] na6_reg, nb6_reg;
    logic [DEN_BITS:0]   den6_reg;
    logic [TB:0]         t6_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v6_reg <= 1'b0;
        else if (en) v6_reg <= v5_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na6_reg  <= {NUM_BITS'(mx5) * NUM_BITS'(ovl5_reg), 1'b0} + QUO_BITS'(den5_reg);
            nb6_reg  <= {NUM_BITS'(my5) * NUM_BITS'(ovl5_reg), 1'b0} + QUO_BITS'(den5_reg);
            den6_reg <= {den5_reg, 1'b0};
            t6_reg   <= t5_reg;
        end
    end

    logic dv;
    logic [QUO_BITS-1:0] qa, qb;
    logic [TB:0] dt;
    rrp_div #(.NUM_W(QUO_BITS), .DEN_W(DEN_BITS+1), .TAG_BITS(TB+1)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v6_reg), .in_num_a(na6_reg), .in_num_b(nb6_reg),
        .in_den(den6_reg), .in_tag(t6_reg),
        .out_valid(dv), .out_quo_a(qa), .out_quo_b(qb), .out_tag(dt)
    );

    logic signed [CW-1:0]   px_d, py_d;
    logic                   sx_d, sy_d, in_d;
    assign in_d = dt[TB];
    assign px_d = dt[TB-1 -: CW];
    assign py_d = dt[TB-1-CW -: CW];
    assign sx_d = dt[RADIUS_BITS+1];
    assign sy_d = dt[RADIUS_BITS];

    // final: apply offset, saturate
    localparam int SW = QUO_BITS + 2;
    localparam logic signed [SW-1:0] HI = SW'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic signed [SW-1:0] LO = -HI - SW'(1);
    logic signed [SW-1:0] sum_x, sum_y;
    logic signed [CW-1:0] nx, ny;
    always_comb
    begin
        sum_x = SW'(px_d) + (sx_d ? -SW'(qa) : SW'(qa));
        sum_y = SW'(py_d) + (sy_d ? -SW'(qb) : SW'(qb));
        nx = (sum_x > HI) ? HI[CW-1:0] : (sum_x < LO) ? LO[CW-1:0] : sum_x[CW-1:0];
        ny = (sum_y > HI) ? HI[CW-1:0] : (sum_y < LO) ? LO[CW-1:0] : sum_y[CW-1:0];
    end

    logic ov_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) ov_reg <= 1'b0;
        else if (en) ov_reg <= dv;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_ch.data.new_x <= in_d ? nx : px_d;
            out_ch.data.new_y <= in_d ? ny : py_d;
            out_ch.data.moved <= in_d;
        end
    end
    assign out_ch.valid = ov_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("output changed while stalled");
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !$isunknown(out_ch.data))
        else $error("unknown result data");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v6_reg) && $stable(v4_reg))
        else $error("pipe advanced during stall");
endmodule

>>> rtl/core/rrp_sqrt.sv
// ----------------------------------------------------------------------------
// rrp_sqrt
// Pipelined restoring square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rrp_sqrt #(
    parameter int IN_BITS  = 41,
    parameter int OUT_BITS = 21,
    parameter int TAG_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IN_BITS-1:0]  in_rad,
    input  logic [TAG_BITS-1:0] in_tag,
    output logic                out_valid,
    output logic [OUT_BITS-1:0] out_root,
    output logic [TAG_BITS-1:0] out_tag
);
    localparam int RW = 2 * OUT_BITS;
    localparam int PW = OUT_BITS + 2;

    logic [OUT_BITS-1:0] vld_reg;
    logic [RW-1:0]       rad_reg  [OUT_BITS];
    logic [PW-1:0]       rem_reg  [OUT_BITS];
    logic [OUT_BITS-1:0] root_reg [OUT_BITS];
    logic [TAG_BITS-1:0] tag_reg  [OUT_BITS];

    logic [OUT_BITS-1:0] vld_in;
    logic [RW-1:0]       rad_in   [OUT_BITS];
    logic [PW-1:0]       rem_in   [OUT_BITS];
    logic [OUT_BITS-1:0] root_in  [OUT_BITS];
    logic [TAG_BITS-1:0] tag_in   [OUT_BITS];
    logic [PW-1:0]       rem_sh   [OUT_BITS];
    logic [PW-1:0]       trial    [OUT_BITS];
    logic [OUT_BITS-1:0] ok;

    assign vld_in = {vld_reg[OUT_BITS-2:0], in_valid};

    always_comb
    begin
        rad_in[0]  = RW'(in_rad);
        rem_in[0]  = '0;
        root_in[0] = '0;
        tag_in[0]  = in_tag;
        for (int i = 1; i < OUT_BITS; i++)
        begin
            rad_in[i]  = rad_reg[i-1];
            rem_in[i]  = rem_reg[i-1];
            root_in[i] = root_reg[i-1];
            tag_in[i]  = tag_reg[i-1];
        end
        for (int i = 0; i < OUT_BITS; i++)
        begin
            rem_sh[i] = {rem_in[i][PW-3:0], rad_in[i][RW-1 -: 2]};
            trial[i]  = {root_in[i], 2'b01};
            ok[i]     = rem_sh[i] >= trial[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < OUT_BITS; i++)
            begin
                rad_reg[i]  <= rad_in[i] << 2;
                rem_reg[i]  <= ok[i] ? rem_sh[i] - trial[i] : rem_sh[i];
                root_reg[i] <= {root_in[i][OUT_BITS-2:0], ok[i]};
                tag_reg[i]  <= tag_in[i];
            end
        end
    end

    assign out_valid = vld_reg[OUT_BITS-1];
    assign out_root  = root_reg[OUT_BITS-1];
    assign out_tag   = tag_reg[OUT_BITS-1];
endmodule

>>> rtl/core/rrp_div.sv
// ----------------------------------------------------------------------------
// rrp_div
// Pipelined restoring divider for two numerators sharing one divisor.
// ----------------------------------------------------------------------------
module rrp_div #(
    parameter int NUM_W    = 33,
    parameter int DEN_W    = 24,
    parameter int TAG_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [NUM_W-1:0]    in_num_a,
    input  logic [NUM_W-1:0]    in_num_b,
    input  logic [DEN_W-1:0]    in_den,
    input  logic [TAG_BITS-1:0] in_tag,
    output logic                out_valid,
    output logic [NUM_W-1:0]    out_quo_a,
    output logic [NUM_W-1:0]    out_quo_b,
    output logic [TAG_BITS-1:0] out_tag
);
    localparam int RW = DEN_W + 1;

    logic [NUM_W-1:0]    vld_reg;
    logic [NUM_W-1:0]    na_reg  [NUM_W];
    logic [NUM_W-1:0]    nb_reg  [NUM_W];
    logic [RW-1:0]       ra_reg  [NUM_W];
    logic [RW-1:0]       rb_reg  [NUM_W];
    logic [DEN_W-1:0]    den_reg [NUM_W];
    logic [TAG_BITS-1:0] tag_reg [NUM_W];

    logic [NUM_W-1:0]    vld_in;
    logic [NUM_W-1:0]    na_in   [NUM_W];
    logic [NUM_W-1:0]    nb_in   [NUM_W];
    logic [RW-1:0]       ra_in   [NUM_W];
    logic [RW-1:0]       rb_in   [NUM_W];
    logic [DEN_W-1:0]    den_in  [NUM_W];
    logic [TAG_BITS-1:0] tag_in  [NUM_W];
    logic [RW-1:0]       sa      [NUM_W];
    logic [RW-1:0]       sb      [NUM_W];
    logic [NUM_W-1:0]    oka;
    logic [NUM_W-1:0]    okb;

    assign vld_in = {vld_reg[NUM_W-2:0], in_valid};

    // numerator register shifts out its top bit and takes in the quotient bit
    always_comb
    begin
        na_in[0]  = in_num_a;
        nb_in[0]  = in_num_b;
        ra_in[0]  = '0;
        rb_in[0]  = '0;
        den_in[0] = in_den;
        tag_in[0] = in_tag;
        for (int i = 1; i < NUM_W; i++)
        begin
            na_in[i]  = na_reg[i-1];
            nb_in[i]  = nb_reg[i-1];
            ra_in[i]  = ra_reg[i-1];
            rb_in[i]  = rb_reg[i-1];
            den_in[i] = den_reg[i-1];
            tag_in[i] = tag_reg[i-1];
        end
        for (int i = 0; i < NUM_W; i++)
        begin
            sa[i]  = {ra_in[i][RW-2:0], na_in[i][NUM_W-1]};
            sb[i]  = {rb_in[i][RW-2:0], nb_in[i][NUM_W-1]};
            oka[i] = sa[i] >= RW'(den_in[i]);
            okb[i] = sb[i] >= RW'(den_in[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_W; i++)
            begin
                ra_reg[i]  <= oka[i] ? sa[i] - RW'(den_in[i]) : sa[i];
                rb_reg[i]  <= okb[i] ? sb[i] - RW'(den_in[i]) : sb[i];
                na_reg[i]  <= {na_in[i][NUM_W-2:0], oka[i]};
                nb_reg[i]  <= {nb_in[i][NUM_W-2:0], okb[i]};
                den_reg[i] <= den_in[i];
                tag_reg[i] <= tag_in[i];
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign out_quo_a = na_reg[NUM_W-1];
    assign out_quo_b = nb_reg[NUM_W-1];
    assign out_tag   = tag_reg[NUM_W-1];
endmodule
